// ===== rtl/ecaf_pkg.sv =====
`timescale 1ns / 1ps

package ecaf_pkg;

    localparam int SENSOR_ROWS      = 128;
    localparam int SENSOR_COLUMNS   = 128;
    localparam int NEIGHBOUR_RADIUS = 1;

    localparam int MAP_ROWS = SENSOR_ROWS + 2 * NEIGHBOUR_RADIUS;
    localparam int MAP_COLS = SENSOR_COLUMNS + 2 * NEIGHBOUR_RADIUS;
    localparam int MAP_SIZE = MAP_ROWS * MAP_COLS;
    localparam int MAP_AW   = $clog2(MAP_SIZE);

    localparam int SPAN   = 2 * NEIGHBOUR_RADIUS + 1;
    localparam int SPAN_W = $clog2(SPAN + 1);

    localparam logic [MAP_AW-1:0] CENTRE_OFS =
        MAP_AW'(NEIGHBOUR_RADIUS * MAP_COLS + NEIGHBOUR_RADIUS);
    localparam logic [MAP_AW-1:0] ROW_STEP   = MAP_AW'(MAP_COLS - 2 * NEIGHBOUR_RADIUS);
    localparam logic [MAP_AW-1:0] MAP_LAST   = MAP_AW'(MAP_SIZE - 1);
    localparam logic [SPAN_W-1:0] SPAN_LAST  = SPAN_W'(SPAN - 1);

    localparam int TIME_W   = 32;
    localparam int RAW_W    = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] WRAP_STEP         = 32'h0400_0000;
    localparam logic [TIME_W-1:0] THRESHOLD_RESET   = 32'd10000;
    localparam logic [TIME_W-1:0] FRAME_RESET       = 32'd10000;
    localparam logic [3:0]        MARGIN_RESET      = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUPPORT_THRESHOLD = 2'd0,
        CFG_FRAME_INTERVAL    = 2'd1,
        CFG_COORD_MARGIN      = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             is_wrap_marker;
        logic [RAW_W-1:0] time_low;
        logic [6:0]       pixel_column;
        logic [6:0]       pixel_row;
        logic             on_polarity;
        logic             chosen_camera;
    } t_in_item;

    typedef struct packed {
        logic              event_passes;
        logic [7:0]        out_row;
        logic [7:0]        out_column;
        logic              out_polarity;
        logic [TIME_W-1:0] full_time;
        logic              frame_tick;
    } t_out_item;

endpackage

// ===== rtl/ecaf_ram.sv =====
`timescale 1ns / 1ps

module ecaf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/event_camera_activity_filter_top.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | i_in  (t_in_item)
// out     | output    | o_out_valid / i_out_stall  | o_out (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an event that is kept takes these steps: an accept cycle, then one map write per
// cycle over the (2R+1)^2 neighbourhood (centre read in the first), then forming the
// result once the output register is free or unstalled. wrap markers and dropped events
// end at acceptance. after reset both maps are zeroed one entry a cycle, all MAP_SIZE
// (16900) entries, with the input stalled; config writes are taken at all times.
// a result waits in the output register under stall while the next item is taken.

module event_camera_activity_filter_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ecaf_pkg::t_in_item     i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ecaf_pkg::t_out_item    o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [ecaf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ecaf_pkg::TIME_W-1:0]    i_cfg_data
);

    import ecaf_pkg::*;

    t_state            r_state, n_state;
    logic [MAP_AW-1:0] r_addr, n_addr;
    logic [SPAN_W-1:0] r_dc, n_dc;
    logic [SPAN_W-1:0] r_dr, n_dr;
    logic [TIME_W-1:0] r_offset, n_offset;
    logic [TIME_W-1:0] r_last_tick, n_last_tick;
    logic [TIME_W-1:0] r_thresh;
    logic [TIME_W-1:0] r_frame;
    logic [3:0]        r_margin;
    logic              r_out_valid, n_out_valid;

    logic [TIME_W-1:0] r_now, n_now;
    logic [6:0]        r_row, n_row;
    logic [6:0]        r_col, n_col;
    logic              r_pol, n_pol;
    t_out_item         r_out, n_out;

    logic              in_acc;
    logic              in_range;
    logic              mem_we_on;
    logic              mem_we_off;
    logic              mem_re;
    logic [TIME_W-1:0] mem_wdata;
    logic [MAP_AW-1:0] mem_raddr;
    logic [TIME_W-1:0] on_q;
    logic [TIME_W-1:0] off_q;
    logic [TIME_W-1:0] before_time;
    logic [TIME_W-1:0] tick_gap;
    logic              tick;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_range = (int'(i_in.pixel_row) < SENSOR_ROWS)
                   && (int'(i_in.pixel_column) < SENSOR_COLUMNS);

    assign before_time = r_pol ? on_q : off_q;
    assign tick_gap    = r_now - r_last_tick;
    assign tick        = tick_gap > r_frame;

    assign mem_re     = (r_state == S_RUN) && (r_dc == '0) && (r_dr == '0);
    assign mem_raddr  = r_addr + CENTRE_OFS;
    assign mem_wdata  = (r_state == S_CLEAR) ? '0 : r_now;
    assign mem_we_on  = (r_state == S_CLEAR) || ((r_state == S_RUN) && r_pol);
    assign mem_we_off = (r_state == S_CLEAR) || ((r_state == S_RUN) && !r_pol);

    ecaf_ram #(
        .WIDTH(TIME_W),
        .DEPTH(MAP_SIZE)
    ) u_on_map (
        .i_clk  (i_clk),
        .i_we   (mem_we_on),
        .i_waddr(r_addr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(on_q)
    );

    ecaf_ram #(
        .WIDTH(TIME_W),
        .DEPTH(MAP_SIZE)
    ) u_off_map (
        .i_clk  (i_clk),
        .i_we   (mem_we_off),
        .i_waddr(r_addr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(off_q)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_dc        = r_dc;
        n_dr        = r_dr;
        n_offset    = r_offset;
        n_last_tick = r_last_tick;
        n_out_valid = r_out_valid && i_out_stall;
        n_now       = r_now;
        n_row       = r_row;
        n_col       = r_col;
        n_pol       = r_pol;
        n_out       = r_out;

        unique case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == MAP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.is_wrap_marker) begin
                        n_offset = r_offset + WRAP_STEP;
                    end else if (i_in.chosen_camera && in_range) begin
                        n_now   = r_offset + TIME_W'(i_in.time_low);
                        n_row   = i_in.pixel_row;
                        n_col   = i_in.pixel_column;
                        n_pol   = i_in.on_polarity;
                        n_addr  = MAP_AW'(int'(i_in.pixel_row) * MAP_COLS
                                          + int'(i_in.pixel_column));
                        n_dc    = '0;
                        n_dr    = '0;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_dc == SPAN_LAST) begin
                    n_dc   = '0;
                    n_dr   = r_dr + 1'b1;
                    n_addr = r_addr + ROW_STEP;
                    if (r_dr == SPAN_LAST) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_dc   = r_dc + 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.event_passes = (r_now - before_time) <= r_thresh;
                    n_out.out_row      = 8'(r_row) + 8'(r_margin);
                    n_out.out_column   = 8'(r_col) + 8'(r_margin);
                    n_out.out_polarity = r_pol;
                    n_out.full_time    = r_now;
                    n_out.frame_tick   = tick;
                    n_out_valid        = 1'b1;
                    if (tick) begin
                        n_last_tick = r_now;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_dc        <= '0;
            r_dr        <= '0;
            r_offset    <= '0;
            r_last_tick <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESHOLD_RESET;
            r_frame     <= FRAME_RESET;
            r_margin    <= MARGIN_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_dc        <= n_dc;
            r_dr        <= n_dr;
            r_offset    <= n_offset;
            r_last_tick <= n_last_tick;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SUPPORT_THRESHOLD: r_thresh <= i_cfg_data;
                    CFG_FRAME_INTERVAL:    r_frame  <= i_cfg_data;
                    CFG_COORD_MARGIN:      r_margin <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_row <= n_row;
        r_col <= n_col;
        r_pol <= n_pol;
        r_out <= n_out;
    end

endmodule
